### src/deur_pkg.sv
package deur_pkg;

	// Build-time defaults
	localparam int DEUR_CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES       = 24;

	// Port field widths
	localparam int ANG_W       = 18;
	localparam int ZEN_OUT_W   = 17;
	localparam int TDATA_IN_W  = 40;
	localparam int TDATA_OUT_W = 40;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 18;

	// Internal datapath widths (Q30 fixed point)
	localparam int AW      = 34;        // sin/cos angle accumulator
	localparam int DW      = 33;        // sin/cos and matrix values
	localparam int PROD_W  = 2 * DW;
	localparam int SUM_W   = PROD_W + 2;
	localparam int VW      = 34;        // atan2 x/y
	localparam int VZW     = 35;        // atan2 angle accumulator
	localparam int NW_W    = 32;        // clamped w'
	localparam int SQW     = 62;        // square root remainder / root
	localparam int ROOT_W  = 31;
	localparam int Q_W     = VZW - 15;  // angle after scaling to Q3.15
	localparam int SQRT_STEPS = 31;

	// Lanes of the sin/cos chain
	localparam int ROT_LANES = 5;
	localparam int LANE_ZEN  = 0;
	localparam int LANE_AZ   = 1;
	localparam int LANE_FZ   = 2;
	localparam int LANE_TILT = 3;
	localparam int LANE_SZ   = 4;

	// Lanes of the atan2 chain
	localparam int VEC_LANES = 2;
	localparam int VLANE_AZ  = 0;
	localparam int VLANE_ZEN = 1;

	// Constants
	localparam int Q15_PI_I      = 102944;
	localparam int Q15_HALF_PI_I = 51472;
	localparam int Q30_ONE       = 1073741824;
	localparam int CORDIC_GAIN   = 652032874;
	localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
	localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;

	localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_Z  = 2'd0,
		REG_Y_TILT   = 2'd1,
		REG_SECOND_Z = 2'd2
	} cfg_reg_t;

	// Control travelling with every request
	typedef struct packed {
		logic vld;
		logic err;
	} side_t;

	// Rotated vector carried through the square root chain
	typedef struct packed {
		logic signed [VW-1:0]   nu;
		logic signed [VW-1:0]   nv;
		logic signed [NW_W-1:0] nw;
	} sq_pay_t;

	// Q30 product with round half up
	function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
	                                              input logic signed [DW-1:0] b);
		logic signed [PROD_W-1:0] p;
		p = a * b;
		p = p + PROD_W'(536870912);
		return p[DW+29:30];
	endfunction

endpackage

### src/deur_rot_cell.sv
module deur_rot_cell
	import deur_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  side_t                side_i,
	input  logic signed [DW-1:0] x_i [ROT_LANES],
	input  logic signed [DW-1:0] y_i [ROT_LANES],
	input  logic signed [AW-1:0] z_i [ROT_LANES],
	input  logic                 flip_i [ROT_LANES],
	output side_t                side_o,
	output logic signed [DW-1:0] x_o [ROT_LANES],
	output logic signed [DW-1:0] y_o [ROT_LANES],
	output logic signed [AW-1:0] z_o [ROT_LANES],
	output logic                 flip_o [ROT_LANES]
);

	localparam logic signed [AW-1:0] ATAN_A = AW'(ATAN_TAB[IDX]);

	side_t                side_q;
	logic signed [DW-1:0] x_d [ROT_LANES];
	logic signed [DW-1:0] y_d [ROT_LANES];
	logic signed [AW-1:0] z_d [ROT_LANES];
	logic signed [DW-1:0] x_q [ROT_LANES];
	logic signed [DW-1:0] y_q [ROT_LANES];
	logic signed [AW-1:0] z_q [ROT_LANES];
	logic                 flip_q [ROT_LANES];

	// One rotation step per lane, direction from the residual angle sign
	always_comb begin
		for (int l = 0; l < ROT_LANES; l++) begin
			if (!z_i[l][AW-1]) begin
				x_d[l] = x_i[l] - (y_i[l] >>> IDX);
				y_d[l] = y_i[l] + (x_i[l] >>> IDX);
				z_d[l] = z_i[l] - ATAN_A;
			end else begin
				x_d[l] = x_i[l] + (y_i[l] >>> IDX);
				y_d[l] = y_i[l] - (x_i[l] >>> IDX);
				z_d[l] = z_i[l] + ATAN_A;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= x_d;
			y_q    <= y_d;
			z_q    <= z_d;
			flip_q <= flip_i;
		end
	end

	assign side_o = side_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;
	assign flip_o = flip_q;

endmodule

### src/deur_rotate.sv
module deur_rotate
	import deur_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  side_t                side_i,
	input  logic signed [DW-1:0] sin_i [ROT_LANES],
	input  logic signed [DW-1:0] cos_i [ROT_LANES],
	output side_t                side_o,
	output sq_pay_t              pay_o,
	output logic [SQW-1:0]       rad_o
);

	localparam logic signed [SUM_W-1:0] RND_S   = SUM_W'(536870912);
	localparam logic signed [VW-1:0]    ONE_V   = VW'(Q30_ONE);
	localparam logic [SQW-1:0]          ONE_SQ  = SQW'(1) << 60;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5;

	// Stage 1: unit vector and first matrix products
	logic signed [DW-1:0] u_s1, v_s1, w_s1;
	logic signed [DW-1:0] cpcb_s1, spcb_s1, spsg_s1, spcg_s1, cpsg_s1, cpcg_s1;
	logic signed [DW-1:0] r02_s1, r12_s1, sbcg_s1, sbsg_s1, cb_s1, cg_s1, sg_s1;

	// Stage 2: matrix entries
	logic signed [DW-1:0] r_s2 [9];
	logic signed [DW-1:0] uvw_s2 [3];

	// Stage 3: matrix times vector products
	logic signed [PROD_W-1:0] p_c  [9];
	logic signed [PROD_W-1:0] p_s3 [9];

	// Stage 4: rotated vector
	logic signed [SUM_W-1:0] sum_u, sum_v, sum_w;
	logic signed [VW-1:0]    nw_full;
	logic signed [NW_W-1:0]  nw_c;
	logic signed [VW-1:0]    nu_s4, nv_s4;
	logic signed [NW_W-1:0]  nw_s4;

	// Stage 5: radicand 1 - w'^2
	logic signed [2*NW_W-1:0] sq_c;
	sq_pay_t                  pay_s5;
	logic [SQW-1:0]           rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else if (en) begin
			side_s1 <= side_i;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= qmul(sin_i[LANE_ZEN], cos_i[LANE_AZ]);
			v_s1    <= qmul(sin_i[LANE_ZEN], sin_i[LANE_AZ]);
			w_s1    <= cos_i[LANE_ZEN];
			cpcb_s1 <= qmul(cos_i[LANE_FZ], cos_i[LANE_TILT]);
			spcb_s1 <= qmul(sin_i[LANE_FZ], cos_i[LANE_TILT]);
			spsg_s1 <= qmul(sin_i[LANE_FZ], sin_i[LANE_SZ]);
			spcg_s1 <= qmul(sin_i[LANE_FZ], cos_i[LANE_SZ]);
			cpsg_s1 <= qmul(cos_i[LANE_FZ], sin_i[LANE_SZ]);
			cpcg_s1 <= qmul(cos_i[LANE_FZ], cos_i[LANE_SZ]);
			r02_s1  <= qmul(cos_i[LANE_FZ], sin_i[LANE_TILT]);
			r12_s1  <= qmul(sin_i[LANE_FZ], sin_i[LANE_TILT]);
			sbcg_s1 <= qmul(sin_i[LANE_TILT], cos_i[LANE_SZ]);
			sbsg_s1 <= qmul(sin_i[LANE_TILT], sin_i[LANE_SZ]);
			cb_s1   <= cos_i[LANE_TILT];
			cg_s1   <= cos_i[LANE_SZ];
			sg_s1   <= sin_i[LANE_SZ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2[0]   <= qmul(cpcb_s1, cg_s1) - spsg_s1;
			r_s2[1]   <= -spcg_s1 - qmul(cpcb_s1, sg_s1);
			r_s2[2]   <= r02_s1;
			r_s2[3]   <= qmul(spcb_s1, cg_s1) + cpsg_s1;
			r_s2[4]   <= cpcg_s1 - qmul(spcb_s1, sg_s1);
			r_s2[5]   <= r12_s1;
			r_s2[6]   <= -sbcg_s1;
			r_s2[7]   <= sbsg_s1;
			r_s2[8]   <= cb_s1;
			uvw_s2[0] <= u_s1;
			uvw_s2[1] <= v_s1;
			uvw_s2[2] <= w_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			p_c[k] = r_s2[k] * uvw_s2[k % 3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= p_c;
		end
	end

	// Sum each row, round once, clamp w' to plus or minus one
	always_comb begin
		sum_u   = SUM_W'(p_s3[0]) + SUM_W'(p_s3[1]) + SUM_W'(p_s3[2]) + RND_S;
		sum_v   = SUM_W'(p_s3[3]) + SUM_W'(p_s3[4]) + SUM_W'(p_s3[5]) + RND_S;
		sum_w   = SUM_W'(p_s3[6]) + SUM_W'(p_s3[7]) + SUM_W'(p_s3[8]) + RND_S;
		nw_full = sum_w[VW+29:30];
		if (nw_full > ONE_V) begin
			nw_c = NW_W'(ONE_V);
		end else if (nw_full < -ONE_V) begin
			nw_c = NW_W'(-ONE_V);
		end else begin
			nw_c = NW_W'(nw_full);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nu_s4 <= sum_u[VW+29:30];
			nv_s4 <= sum_v[VW+29:30];
			nw_s4 <= nw_c;
		end
	end

	assign sq_c = nw_s4 * nw_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s5 <= '{nu: nu_s4, nv: nv_s4, nw: nw_s4};
			rad_s5 <= ONE_SQ - SQW'($unsigned(sq_c));
		end
	end

	assign side_o = side_s5;
	assign pay_o  = pay_s5;
	assign rad_o  = rad_s5;

endmodule

### src/deur_sqrt_cell.sv
module deur_sqrt_cell
	import deur_pkg::*;
#(
	parameter int K = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  side_t          side_i,
	input  sq_pay_t        pay_i,
	input  logic [SQW-1:0] n_i,
	input  logic [SQW-1:0] r_i,
	output side_t          side_o,
	output sq_pay_t        pay_o,
	output logic [SQW-1:0] n_o,
	output logic [SQW-1:0] r_o
);

	localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

	side_t          side_q;
	sq_pay_t        pay_q;
	logic [SQW-1:0] trial;
	logic [SQW-1:0] n_d, r_d, n_q, r_q;

	// One root bit: subtract the trial value when it fits
	always_comb begin
		trial = r_i + BIT;
		if (n_i >= trial) begin
			n_d = n_i - trial;
			r_d = (r_i >> 1) + BIT;
		end else begin
			n_d = n_i;
			r_d = r_i >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= pay_i;
			n_q   <= n_d;
			r_q   <= r_d;
		end
	end

	assign side_o = side_q;
	assign pay_o  = pay_q;
	assign n_o    = n_q;
	assign r_o    = r_q;

endmodule

### src/deur_vec_cell.sv
module deur_vec_cell
	import deur_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  side_t                 side_i,
	input  logic signed [VW-1:0]  x_i [VEC_LANES],
	input  logic signed [VW-1:0]  y_i [VEC_LANES],
	input  logic signed [VZW-1:0] z_i [VEC_LANES],
	input  logic                  zero_i [VEC_LANES],
	output side_t                 side_o,
	output logic signed [VW-1:0]  x_o [VEC_LANES],
	output logic signed [VW-1:0]  y_o [VEC_LANES],
	output logic signed [VZW-1:0] z_o [VEC_LANES],
	output logic                  zero_o [VEC_LANES]
);

	localparam logic signed [VZW-1:0] ATAN_V = VZW'(ATAN_TAB[IDX]);

	side_t                 side_q;
	logic signed [VW-1:0]  x_d [VEC_LANES];
	logic signed [VW-1:0]  y_d [VEC_LANES];
	logic signed [VZW-1:0] z_d [VEC_LANES];
	logic signed [VW-1:0]  x_q [VEC_LANES];
	logic signed [VW-1:0]  y_q [VEC_LANES];
	logic signed [VZW-1:0] z_q [VEC_LANES];
	logic                  zero_q [VEC_LANES];

	// Vectoring step: drive y toward zero, collect the angle
	always_comb begin
		for (int l = 0; l < VEC_LANES; l++) begin
			if (y_i[l][VW-1]) begin
				x_d[l] = x_i[l] - (y_i[l] >>> IDX);
				y_d[l] = y_i[l] + (x_i[l] >>> IDX);
				z_d[l] = z_i[l] - ATAN_V;
			end else begin
				x_d[l] = x_i[l] + (y_i[l] >>> IDX);
				y_d[l] = y_i[l] - (x_i[l] >>> IDX);
				z_d[l] = z_i[l] + ATAN_V;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= x_d;
			y_q    <= y_d;
			z_q    <= z_d;
			zero_q <= zero_i;
		end
	end

	assign side_o = side_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;
	assign zero_o = zero_q;

endmodule

### src/direction_euler_rotation_unit.sv
// Rotates one track direction (zenith, azimuth in Q3.15 radians) by the Z-Y-Z Euler
// angles held in the three configuration registers and returns the new azimuth and
// zenith. Fully pipelined: one request is accepted every clock while the skid entry
// is empty. A request passes in order the prep register, the sin/cos CORDIC chain
// (CORDIC_STAGES cells), the five matrix stages, the 31-cell square root chain, the
// atan2 prep register, the atan2 CORDIC chain (CORDIC_STAGES cells) and the result
// and output registers. Register values are sampled when a request is accepted, so a
// write takes effect for the next request. An output register with a one-entry skid
// keeps input ready high while a result waits; s_axis_tready depends on registers only.
// Out-of-range input gives tuser = 1 with both angles zero.
module direction_euler_rotation_unit
	import deur_pkg::*;
#(
	parameter int CORDIC_STAGES = DEUR_CORDIC_STAGES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // zenith_in, azimuth_in
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // azimuth_out, zenith_out
	output logic                   m_axis_tuser,   // status
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic signed [ANG_W-1:0] PI15      = ANG_W'(Q15_PI_I);
	localparam logic signed [ANG_W-1:0] HALF_PI15 = ANG_W'(Q15_HALF_PI_I);
	localparam logic signed [AW-1:0]    PI_A      = AW'(Q30_PI);
	localparam logic signed [AW-1:0]    HALF_PI_A = AW'(Q30_HALF_PI);
	localparam logic signed [VZW-1:0]   PI_V      = VZW'(Q30_PI);
	localparam logic signed [VZW-1:0]   RND15     = VZW'(16384);
	localparam logic signed [Q_W-1:0]   PI_Q      = Q_W'(Q15_PI_I);

	logic en, acc;

	// Configuration registers
	logic signed [ANG_W-1:0] first_z_q, y_tilt_q, second_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_z_q  <= '0;
			y_tilt_q   <= '0;
			second_z_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FIRST_Z:  first_z_q  <= cfg_data;
				REG_Y_TILT:   y_tilt_q   <= cfg_data;
				REG_SECOND_Z: second_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the whole pipe advances unless the skid entry is full
	logic skid_vld_q;
	assign en            = !skid_vld_q;
	assign s_axis_tready = en;
	assign acc           = s_axis_tvalid && en;

	// Prep: range check, scale to Q30, fold into plus or minus pi/2
	logic signed [ANG_W-1:0] ang [ROT_LANES];
	logic signed [AW-1:0]    zf [ROT_LANES];
	logic signed [AW-1:0]    z_c [ROT_LANES];
	logic                    flip_c [ROT_LANES];
	logic                    err_c;

	assign ang[LANE_ZEN]  = s_axis_tdata[ANG_W-1:0];
	assign ang[LANE_AZ]   = s_axis_tdata[2*ANG_W-1:ANG_W];
	assign ang[LANE_FZ]   = first_z_q;
	assign ang[LANE_TILT] = y_tilt_q;
	assign ang[LANE_SZ]   = second_z_q;

	assign err_c = ang[LANE_ZEN][ANG_W-1] || (ang[LANE_ZEN] > HALF_PI15)
		|| (ang[LANE_AZ] < -PI15) || (ang[LANE_AZ] > PI15);

	always_comb begin
		for (int l = 0; l < ROT_LANES; l++) begin
			zf[l] = AW'(ang[l]) <<< 15;
			if (zf[l] > HALF_PI_A) begin
				z_c[l]    = zf[l] - PI_A;
				flip_c[l] = 1'b1;
			end else if (zf[l] < -HALF_PI_A) begin
				z_c[l]    = zf[l] + PI_A;
				flip_c[l] = 1'b1;
			end else begin
				z_c[l]    = zf[l];
				flip_c[l] = 1'b0;
			end
		end
	end

	side_t                side_s1;
	logic signed [AW-1:0] z_s1 [ROT_LANES];
	logic                 flip_s1 [ROT_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= '{vld: acc, err: err_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= z_c;
			flip_s1 <= flip_c;
		end
	end

	// Sin/cos chain
	side_t                rs [CORDIC_STAGES+1];
	logic signed [DW-1:0] rx [CORDIC_STAGES+1][ROT_LANES];
	logic signed [DW-1:0] ry [CORDIC_STAGES+1][ROT_LANES];
	logic signed [AW-1:0] rz [CORDIC_STAGES+1][ROT_LANES];
	logic                 rf [CORDIC_STAGES+1][ROT_LANES];

	assign rs[0] = side_s1;
	always_comb begin
		for (int l = 0; l < ROT_LANES; l++) begin
			rx[0][l] = DW'(CORDIC_GAIN);
			ry[0][l] = '0;
			rz[0][l] = z_s1[l];
			rf[0][l] = flip_s1[l];
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		deur_rot_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (rs[g]),
			.x_i    (rx[g]),
			.y_i    (ry[g]),
			.z_i    (rz[g]),
			.flip_i (rf[g]),
			.side_o (rs[g+1]),
			.x_o    (rx[g+1]),
			.y_o    (ry[g+1]),
			.z_o    (rz[g+1]),
			.flip_o (rf[g+1])
		);
	end

	// Undo the fold
	logic signed [DW-1:0] sv [ROT_LANES];
	logic signed [DW-1:0] cv [ROT_LANES];

	always_comb begin
		for (int l = 0; l < ROT_LANES; l++) begin
			sv[l] = rf[CORDIC_STAGES][l] ? -ry[CORDIC_STAGES][l] : ry[CORDIC_STAGES][l];
			cv[l] = rf[CORDIC_STAGES][l] ? -rx[CORDIC_STAGES][l] : rx[CORDIC_STAGES][l];
		end
	end

	// Euler matrix and rotated vector
	side_t          qs [SQRT_STEPS+1];
	sq_pay_t        qp [SQRT_STEPS+1];
	logic [SQW-1:0] qn [SQRT_STEPS+1];
	logic [SQW-1:0] qr [SQRT_STEPS+1];

	deur_rotate u_rotate (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.side_i (rs[CORDIC_STAGES]),
		.sin_i  (sv),
		.cos_i  (cv),
		.side_o (qs[0]),
		.pay_o  (qp[0]),
		.rad_o  (qn[0])
	);

	assign qr[0] = '0;

	// Square root chain, one root bit per cell
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		deur_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (qs[j]),
			.pay_i  (qp[j]),
			.n_i    (qn[j]),
			.r_i    (qr[j]),
			.side_o (qs[j+1]),
			.pay_o  (qp[j+1]),
			.n_o    (qn[j+1]),
			.r_o    (qr[j+1])
		);
	end

	// atan2 prep: zero vector flag, move x into the right half plane
	sq_pay_t               pay_e;
	logic [ROOT_W-1:0]     root_e;
	logic signed [VW-1:0]  px [VEC_LANES];
	logic signed [VW-1:0]  py [VEC_LANES];
	logic signed [VW-1:0]  vx_c [VEC_LANES];
	logic signed [VW-1:0]  vy_c [VEC_LANES];
	logic signed [VZW-1:0] vz_c [VEC_LANES];
	logic                  vzero_c [VEC_LANES];

	assign pay_e         = qp[SQRT_STEPS];
	assign root_e        = qr[SQRT_STEPS][ROOT_W-1:0];
	assign px[VLANE_AZ]  = pay_e.nu;
	assign py[VLANE_AZ]  = pay_e.nv;
	assign px[VLANE_ZEN] = VW'(pay_e.nw);
	assign py[VLANE_ZEN] = VW'(root_e);

	always_comb begin
		for (int l = 0; l < VEC_LANES; l++) begin
			vzero_c[l] = (px[l] == '0) && (py[l] == '0);
			if (px[l][VW-1]) begin
				vx_c[l] = -px[l];
				vy_c[l] = -py[l];
				vz_c[l] = py[l][VW-1] ? -PI_V : PI_V;
			end else begin
				vx_c[l] = px[l];
				vy_c[l] = py[l];
				vz_c[l] = '0;
			end
		end
	end

	side_t                 vs [CORDIC_STAGES+1];
	logic signed [VW-1:0]  vx [CORDIC_STAGES+1][VEC_LANES];
	logic signed [VW-1:0]  vy [CORDIC_STAGES+1][VEC_LANES];
	logic signed [VZW-1:0] vz [CORDIC_STAGES+1][VEC_LANES];
	logic                  vzr [CORDIC_STAGES+1][VEC_LANES];
	side_t                 vside_q;
	logic signed [VW-1:0]  vx_q [VEC_LANES];
	logic signed [VW-1:0]  vy_q [VEC_LANES];
	logic signed [VZW-1:0] vz_q [VEC_LANES];
	logic                  vzero_q [VEC_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vside_q <= '0;
		end else if (en) begin
			vside_q <= qs[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_q    <= vx_c;
			vy_q    <= vy_c;
			vz_q    <= vz_c;
			vzero_q <= vzero_c;
		end
	end

	assign vs[0]  = vside_q;
	assign vx[0]  = vx_q;
	assign vy[0]  = vy_q;
	assign vz[0]  = vz_q;
	assign vzr[0] = vzero_q;

	// atan2 chain for both lanes
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
		deur_vec_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (vs[g]),
			.x_i    (vx[g]),
			.y_i    (vy[g]),
			.z_i    (vz[g]),
			.zero_i (vzr[g]),
			.side_o (vs[g+1]),
			.x_o    (vx[g+1]),
			.y_o    (vy[g+1]),
			.z_o    (vz[g+1]),
			.zero_o (vzr[g+1])
		);
	end

	// Result: round to Q3.15 and clamp
	logic signed [VZW-1:0]   tz [VEC_LANES];
	logic signed [Q_W-1:0]   qz [VEC_LANES];
	logic signed [ANG_W-1:0] az_c;
	logic [ZEN_OUT_W-1:0]    zen_c;
	side_t                   side_e;

	assign side_e = vs[CORDIC_STAGES];

	always_comb begin
		for (int l = 0; l < VEC_LANES; l++) begin
			tz[l] = vz[CORDIC_STAGES][l] + RND15;
			qz[l] = vzr[CORDIC_STAGES][l] ? '0 : tz[l][VZW-1:15];
		end
		if (side_e.err) begin
			az_c = '0;
		end else if (qz[VLANE_AZ] < -PI_Q) begin
			az_c = -PI15;
		end else if (qz[VLANE_AZ] > PI_Q) begin
			az_c = PI15;
		end else begin
			az_c = qz[VLANE_AZ][ANG_W-1:0];
		end
		if (side_e.err || qz[VLANE_ZEN][Q_W-1]) begin
			zen_c = '0;
		end else if (qz[VLANE_ZEN] > PI_Q) begin
			zen_c = ZEN_OUT_W'(Q15_PI_I);
		end else begin
			zen_c = qz[VLANE_ZEN][ZEN_OUT_W-1:0];
		end
	end

	logic                    res_vld_q, res_err_q;
	logic signed [ANG_W-1:0] res_az_q;
	logic [ZEN_OUT_W-1:0]    res_zen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= side_e.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_err_q <= side_e.err;
			res_az_q  <= az_c;
			res_zen_q <= zen_c;
		end
	end

	// Output register with one skid entry
	logic                    res_take;
	logic                    out_vld_q, out_err_q, skid_err_q;
	logic signed [ANG_W-1:0] out_az_q, skid_az_q;
	logic [ZEN_OUT_W-1:0]    out_zen_q, skid_zen_q;

	assign res_take = en && res_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res_take;
			end
		end else if (res_take) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q) begin
				out_err_q <= skid_err_q;
				out_az_q  <= skid_az_q;
				out_zen_q <= skid_zen_q;
			end else begin
				out_err_q <= res_err_q;
				out_az_q  <= res_az_q;
				out_zen_q <= res_zen_q;
			end
		end else if (res_take) begin
			skid_err_q <= res_err_q;
			skid_az_q  <= res_az_q;
			skid_zen_q <= res_zen_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_err_q;
	assign m_axis_tdata  = {(TDATA_OUT_W - ANG_W - ZEN_OUT_W)'(0), out_zen_q, out_az_q};

endmodule

### src/deur_checker.sv
module deur_checker
	import deur_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [TDATA_OUT_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	localparam logic signed [ANG_W-1:0] PI15   = ANG_W'(Q15_PI_I);
	localparam logic [ZEN_OUT_W-1:0]    PI15_U = ZEN_OUT_W'(Q15_PI_I);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Error status comes with zero angles
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result with nonzero angles");

	// Valid results stay inside the angle ranges
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
		$signed(m_axis_tdata[ANG_W-1:0]) >= -PI15 &&
		$signed(m_axis_tdata[ANG_W-1:0]) <= PI15 &&
		m_axis_tdata[ANG_W+ZEN_OUT_W-1:ANG_W] <= PI15_U)
		else $error("result angle out of range");

	// Input side only stops after a result was held back
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
		else $error("input ready dropped without output stall");

endmodule

bind direction_euler_rotation_unit deur_checker u_deur_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### bench/deur_checker.sv
`timescale 1ns / 100ps

module deur_scoreboard
	import deur_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [TDATA_OUT_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tuser,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     result_count,
	output int                     range_err_count
);

	localparam int STAGES = DEUR_CORDIC_STAGES;

	typedef struct {
		logic signed [ANG_W-1:0] azimuth;
		logic [ZEN_OUT_W-1:0]    zenith;
		logic                    status;
	} direction_t;

	direction_t rotated_q[$];

	// Euler angles as the block holds them
	longint first_z, y_tilt, second_z;

	// Q30 product, round half up with floor shift
	function automatic longint mul_q30(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint tri_dot(input longint a0, input longint a1, input longint a2,
	                                   input longint u, input longint v, input longint w);
		return (a0 * u + a1 * v + a2 * w + 64'sd536870912) >>> 30;
	endfunction

	// Rotation-mode CORDIC, folded by pi outside +-pi/2
	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint z, x, y, nx;
		bit     flip;
		z = ang * 32768;
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (z > longint'(Q30_HALF_PI)) begin
			z -= longint'(Q30_PI);
			flip = 1;
		end else if (z < -longint'(Q30_HALF_PI)) begin
			z += longint'(Q30_PI);
			flip = 1;
		end
		for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	// Vectoring-mode CORDIC
	function automatic longint arc_tan2(input longint y, input longint x);
		longint z, nx;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(Q30_PI) : -longint'(Q30_PI);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
			if (y < 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic longint int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint scale_q15(input longint z, input longint lo, input longint hi);
		longint q;
		q = (z + 16384) >>> 15;
		if (q < lo) q = lo;
		if (q > hi) q = hi;
		return q;
	endfunction

	function automatic direction_t rotate_direction(input logic [TDATA_IN_W-1:0] req);
		direction_t d;
		longint zen, az, st, ct, sa, ca, sp, cp, sb, cb, sg, cg;
		longint u, v, w, nu, nv, nw, r00, r01, r10, r11, cpcb, spcb, root;
		zen = longint'($signed(req[ANG_W-1:0]));
		az  = longint'($signed(req[2*ANG_W-1:ANG_W]));
		d.azimuth = '0;
		d.zenith  = '0;
		d.status  = 1'b1;
		if (zen < 0 || zen > Q15_HALF_PI_I || az < -Q15_PI_I || az > Q15_PI_I)
			return d;
		sin_cos(zen, st, ct);
		sin_cos(az, sa, ca);
		u = mul_q30(st, ca);
		v = mul_q30(st, sa);
		w = ct;
		sin_cos(first_z, sp, cp);
		sin_cos(y_tilt, sb, cb);
		sin_cos(second_z, sg, cg);
		cpcb = mul_q30(cp, cb);
		spcb = mul_q30(sp, cb);
		r00 = mul_q30(cpcb, cg) - mul_q30(sp, sg);
		r01 = -mul_q30(sp, cg) - mul_q30(cpcb, sg);
		r10 = mul_q30(spcb, cg) + mul_q30(cp, sg);
		r11 = mul_q30(cp, cg) - mul_q30(spcb, sg);
		nu = tri_dot(r00, r01, mul_q30(cp, sb), u, v, w);
		nv = tri_dot(r10, r11, mul_q30(sp, sb), u, v, w);
		nw = tri_dot(-mul_q30(sb, cg), mul_q30(sb, sg), cb, u, v, w);
		// acos argument clamp
		if (nw > Q30_ONE) nw = Q30_ONE;
		if (nw < -longint'(Q30_ONE)) nw = -longint'(Q30_ONE);
		root = int_sqrt(longint'(Q30_ONE) * Q30_ONE - nw * nw);
		d.azimuth = ANG_W'(scale_q15(arc_tan2(nv, nu), -Q15_PI_I, Q15_PI_I));
		d.zenith  = ZEN_OUT_W'(scale_q15(arc_tan2(root, nw), 0, Q15_PI_I));
		d.status  = 1'b0;
		return d;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		fail_count++;
		if (fail_count <= 20)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	assign pending = rotated_q.size();

	// Requests are predicted with the angles held before any same-edge write
	always @(posedge clk or negedge arst_n) begin
		direction_t want;
		if (!arst_n) begin
			first_z  = 0;
			y_tilt   = 0;
			second_z = 0;
			rotated_q.delete();
			fail_count = 0;
			result_count = 0;
			range_err_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				rotated_q = {rotated_q, rotate_direction(s_axis_tdata)};
			if (m_axis_tvalid && m_axis_tready) begin
				result_count++;
				if (m_axis_tuser)
					range_err_count++;
				if (rotated_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 20)
						$display("%0t: result with none expected", $realtime);
				end else begin
					want = rotated_q.pop_front();
					if ($signed(m_axis_tdata[ANG_W-1:0]) != want.azimuth)
						report("azimuth", $signed(m_axis_tdata[ANG_W-1:0]), want.azimuth);
					if (m_axis_tdata[ANG_W+ZEN_OUT_W-1:ANG_W] != want.zenith)
						report("zenith", m_axis_tdata[ANG_W+ZEN_OUT_W-1:ANG_W], want.zenith);
					if (m_axis_tuser != want.status)
						report("status", m_axis_tuser, want.status);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_FIRST_Z:  first_z  = longint'($signed(cfg_data));
					REG_Y_TILT:   y_tilt   = longint'($signed(cfg_data));
					REG_SECOND_Z: second_z = longint'($signed(cfg_data));
					default: ;
				endcase
			end
		end
	end

endmodule

### bench/direction_euler_rotation_unit_tb.sv
`timescale 1ns / 100ps

module direction_euler_rotation_unit_tb;
	import deur_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PIPE_DEPTH = 2 * DEUR_CORDIC_STAGES + 39;
	localparam int HOLD_CYCLES = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int  fail_count, pending, result_count, range_err_count;
	int  send_idle_pct, recv_stall_pct;
	bit  hold_off;
	bit  s_fire;
	int  sent;

	direction_euler_rotation_unit dut (.*);

	deur_scoreboard checker_i (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// request acceptance seen at the rising edge, read back at the falling one
	always @(posedge clk)
		s_fire <= s_axis_tvalid && s_axis_tready;

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 0;
			end
			m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_direction(input logic signed [ANG_W-1:0] zen,
	                              input logic signed [ANG_W-1:0] az);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {4'b0, az, zen};
		do @(negedge clk); while (!s_fire);
		s_axis_tvalid = 1'b0;
		sent++;
	endtask

	task automatic write_angle(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic drain_pipe;
		int guard;
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (PIPE_DEPTH + 10) @(negedge clk);
	endtask

	// Mostly valid directions, some anywhere in the field range
	task automatic send_random;
		logic signed [ANG_W-1:0] zen, az;
		if ($urandom_range(99) < 85) begin
			zen = ANG_W'($urandom_range(Q15_HALF_PI_I));
			az  = ANG_W'(int'($urandom_range(2 * Q15_PI_I)) - Q15_PI_I);
		end else begin
			zen = ANG_W'($urandom);
			az  = ANG_W'($urandom);
		end
		send_direction(zen, az);
	endtask

	int settings [6][3] = '{
		'{0, 0, 0},
		'{102944, -102944, 51472},
		'{-102944, 102944, -102944},
		'{-131072, 131071, 102945},
		'{0, 0, 0},
		'{0, 0, 0}
	};

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_FIRST_Z;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		sent = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Edges of both fields at reset angles, including out-of-range cases
		send_direction(0, 0);
		send_direction(0, 102944);
		send_direction(51472, 102944);
		send_direction(51472, -102944);
		send_direction(51472, 0);
		send_direction(25736, 51472);
		send_direction(-1, 0);
		send_direction(51473, 0);
		send_direction(0, 102945);
		send_direction(0, -102945);
		send_direction(-131072, -131072);
		send_direction(131071, 131071);
		send_direction(1, -1);
		send_direction(51472, 51472);
		drain_pipe();
		// write to the unused index must change nothing
		write_angle(REG_UNUSED, 18'h1FFFF);
		write_angle(REG_Y_TILT, 18'(51472));
		send_direction(0, 0);
		send_direction(51472, 0);
		send_direction(51472, 102944);
		send_direction(25736, -51472);
		drain_pipe();

		for (int p = 0; p < 6; p++) begin
			if (p >= 4) begin
				for (int r = 0; r < 3; r++)
					settings[p][r] = int'($urandom_range(2 * Q15_PI_I)) - Q15_PI_I;
			end
			write_angle(REG_FIRST_Z, 18'(settings[p][0]));
			write_angle(REG_Y_TILT, 18'(settings[p][1]));
			write_angle(REG_SECOND_Z, 18'(settings[p][2]));
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			if (p == 0)
				hold_off = 1;
			for (int k = 0; k < 105; k++)
				send_random();
			send_idle_pct = 0;
			// sender waits until every result is back
			drain_pipe();
		end

		$display("Sent %0d directions over six angle settings and four idling modes;", sent);
		$display("%0d results checked, %0d of them range errors.", result_count, range_err_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
src/deur_pkg.sv
src/deur_rot_cell.sv
src/deur_rotate.sv
src/deur_sqrt_cell.sv
src/deur_vec_cell.sv
src/direction_euler_rotation_unit.sv
src/deur_checker.sv
bench/deur_checker.sv
bench/direction_euler_rotation_unit_tb.sv
